// File: rtl/lc3x_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lc3x_pkg
// types and operation codes shared by the lc-3 execute unit files
// ----------------------------------------------------------------------------
package lc3x_pkg;

    localparam logic [3:0] FN_ADD   = 4'd0;
    localparam logic [3:0] FN_AND   = 4'd1;
    localparam logic [3:0] FN_NOT   = 4'd2;
    localparam logic [3:0] FN_BR    = 4'd3;
    localparam logic [3:0] FN_JMP   = 4'd4;
    localparam logic [3:0] FN_JSR   = 4'd5;
    localparam logic [3:0] FN_LD    = 4'd6;
    localparam logic [3:0] FN_LDI   = 4'd7;
    localparam logic [3:0] FN_LDR   = 4'd8;
    localparam logic [3:0] FN_LEA   = 4'd9;
    localparam logic [3:0] FN_ST    = 4'd10;
    localparam logic [3:0] FN_STI   = 4'd11;
    localparam logic [3:0] FN_STR   = 4'd12;
    localparam logic [3:0] FN_PCINC = 4'd13;
    localparam logic [3:0] FN_MEMWR = 4'd14;

    localparam logic [2:0] CC_N = 3'd4;
    localparam logic [2:0] CC_Z = 3'd2;
    localparam logic [2:0] CC_P = 3'd1;

    localparam logic [2:0] LINK_REG = 3'd7;

    typedef struct packed {
        logic [3:0]  func;
        logic [15:0] instr;
        logic [15:0] load_address;
        logic [15:0] load_data;
    } req_t;

    typedef struct packed {
        logic [15:0] pc_value;
        logic [2:0]  cond_code;
        logic [15:0] written_value;
    } res_t;

    typedef struct packed {
        logic        we;
        logic [2:0]  addr;
        logic [15:0] data;
    } rf_wr_t;

endpackage
`default_nettype wire

// File: rtl/lc3x_regfile.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lc3x_regfile
// eight-word register file, two registered read ports, one write port,
// per-entry valid bits so unwritten registers read as zero
// ----------------------------------------------------------------------------
module lc3x_regfile (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            rd_en,
    input  wire logic [2:0]      rd_addr_a,
    input  wire logic [2:0]      rd_addr_b,
    output logic [15:0]          rd_data_a,
    output logic [15:0]          rd_data_b,
    input  wire lc3x_pkg::rf_wr_t wr
);
    import lc3x_pkg::*;

    logic [15:0] mem [8];
    logic [7:0]  valid_reg;
    logic [15:0] data_a_reg;
    logic [15:0] data_b_reg;
    logic        valid_a_reg;
    logic        valid_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            data_a_reg <= mem[rd_addr_a];
            data_b_reg <= mem[rd_addr_b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            if (wr.we)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                valid_a_reg <= valid_reg[rd_addr_a];
                valid_b_reg <= valid_reg[rd_addr_b];
            end
        end
    end

    assign rd_data_a = valid_a_reg ? data_a_reg : 16'h0000;
    assign rd_data_b = valid_b_reg ? data_b_reg : 16'h0000;

endmodule
`default_nettype wire

// File: rtl/lc3x_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lc3x_mem
// single-port word memory with registered read data
// ----------------------------------------------------------------------------
module lc3x_mem #(
    parameter int ADDR_BITS = 16
) (
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic                 we,
    input  wire logic [ADDR_BITS-1:0] addr,
    input  wire logic [15:0]          wdata,
    output logic [15:0]               rdata
);
    import lc3x_pkg::*;

    logic [15:0] mem [2**ADDR_BITS];
    logic [15:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// File: rtl/lc3_instruction_execute_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lc3_instruction_execute_unit
// executes one lc-3 operation per request on a register file, pc, condition
// code and word memory
// ----------------------------------------------------------------------------
// a request is taken when start is high and busy is low; one result follows,
// shown on result for a single cycle with done high, and it cannot be held
// off. the register file is read at the accepting edge; register, alu, branch,
// jump, lea, st, str, pc increment and memory write requests then execute and
// write back in the ST_REG state; ld, ldr and sti go on to ST_MEM1, and ldi
// to ST_MEM1 and ST_MEM2, each dependent read of the single-port word memory
// adding a state. done rises at the write back edge and busy is already low
// then, so the next request can be issued alongside the strobe.
// ----------------------------------------------------------------------------
module lc3_instruction_execute_unit #(
    parameter int MEM_ADDR_BITS = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire lc3x_pkg::req_t request,
    output logic                done,
    output lc3x_pkg::res_t      result
);
    import lc3x_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_REG  = 4'b0010,
        ST_MEM1 = 4'b0100,
        ST_MEM2 = 4'b1000
    } state_t;

    state_t      state_reg, state_next;
    req_t        req_reg;
    logic [15:0] pc_reg, pc_next;
    logic [2:0]  cc_reg, cc_next;
    res_t        result_reg;
    logic        done_reg;

    logic        accept;
    logic        finish;
    logic [15:0] wv;
    logic        set_cc;
    rf_wr_t      rf_wr;
    logic [15:0] rd_a;
    logic [15:0] rd_b;
    logic        in_store;

    logic        mem_en;
    logic        mem_we;
    logic [15:0] mem_addr;
    logic [15:0] mem_wdata;
    logic [15:0] mem_rdata;

    logic [2:0]  dr;
    logic [15:0] off9;
    logic [15:0] off6;
    logic [15:0] off11;
    logic [15:0] imm5;
    logic [15:0] pc_off9;
    logic [15:0] base_off6;
    logic [15:0] alu_b;

    function automatic logic [2:0] cc_of(input logic [15:0] v);
        logic [2:0] c;
        if (v == 16'h0000)
        begin
            c = CC_Z;
        end
        else if (v[15])
        begin
            c = CC_N;
        end
        else
        begin
            c = CC_P;
        end
        return c;
    endfunction

    assign accept   = start && !busy;
    assign busy     = (state_reg != ST_IDLE);
    assign in_store = (request.func == FN_ST) || (request.func == FN_STI)
                   || (request.func == FN_STR);

    assign dr        = req_reg.instr[11:9];
    assign off9      = {{7{req_reg.instr[8]}}, req_reg.instr[8:0]};
    assign off6      = {{10{req_reg.instr[5]}}, req_reg.instr[5:0]};
    assign off11     = {{5{req_reg.instr[10]}}, req_reg.instr[10:0]};
    assign imm5      = {{11{req_reg.instr[4]}}, req_reg.instr[4:0]};
    assign pc_off9   = pc_reg + off9;
    assign base_off6 = rd_a + off6;
    assign alu_b     = req_reg.instr[5] ? imm5 : rd_b;

    lc3x_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_addr_a (request.instr[8:6]),
        .rd_addr_b (in_store ? request.instr[11:9] : request.instr[2:0]),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b),
        .wr        (rf_wr)
    );

    lc3x_mem #(
        .ADDR_BITS (MEM_ADDR_BITS)
    ) u_mem (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr[MEM_ADDR_BITS-1:0]),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        finish     = 1'b0;
        wv         = 16'h0000;
        set_cc     = 1'b0;
        rf_wr.we   = 1'b0;
        rf_wr.addr = dr;
        rf_wr.data = 16'h0000;
        mem_en     = 1'b0;
        mem_we     = 1'b0;
        mem_addr   = pc_off9;
        mem_wdata  = rd_b;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_REG;
                end
            end
            ST_REG:
            begin
                finish = 1'b1;
                unique case (req_reg.func)
                    FN_ADD:
                    begin
                        wv       = rd_a + alu_b;
                        rf_wr.we = 1'b1;
                        set_cc   = 1'b1;
                    end
                    FN_AND:
                    begin
                        wv       = rd_a & alu_b;
                        rf_wr.we = 1'b1;
                        set_cc   = 1'b1;
                    end
                    FN_NOT:
                    begin
                        wv       = ~rd_a;
                        rf_wr.we = 1'b1;
                        set_cc   = 1'b1;
                    end
                    FN_BR:
                    begin
                        if ((dr & cc_reg) != 3'b000)
                        begin
                            pc_next = pc_off9;
                        end
                    end
                    FN_JMP:
                    begin
                        pc_next = rd_a;
                    end
                    FN_JSR:
                    begin
                        pc_next    = req_reg.instr[11] ? (pc_reg + off11) : rd_a;
                        wv         = pc_reg;
                        rf_wr.we   = 1'b1;
                        rf_wr.addr = LINK_REG;
                    end
                    FN_LD, FN_LDI, FN_STI:
                    begin
                        finish     = 1'b0;
                        mem_en     = 1'b1;
                        state_next = ST_MEM1;
                    end
                    FN_LDR:
                    begin
                        finish     = 1'b0;
                        mem_en     = 1'b1;
                        mem_addr   = base_off6;
                        state_next = ST_MEM1;
                    end
                    FN_LEA:
                    begin
                        wv       = pc_off9;
                        rf_wr.we = 1'b1;
                        set_cc   = 1'b1;
                    end
                    FN_ST:
                    begin
                        wv     = rd_b;
                        mem_en = 1'b1;
                        mem_we = 1'b1;
                    end
                    FN_STR:
                    begin
                        wv       = rd_b;
                        mem_en   = 1'b1;
                        mem_we   = 1'b1;
                        mem_addr = base_off6;
                    end
                    FN_PCINC:
                    begin
                        pc_next = pc_reg + 16'd1;
                    end
                    FN_MEMWR:
                    begin
                        wv        = req_reg.load_data;
                        mem_en    = 1'b1;
                        mem_we    = 1'b1;
                        mem_addr  = req_reg.load_address;
                        mem_wdata = req_reg.load_data;
                    end
                    default:
                    begin
                        wv = 16'h0000;
                    end
                endcase
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MEM1:
            begin
                finish = 1'b1;
                unique case (req_reg.func)
                    FN_LDI:
                    begin
                        finish     = 1'b0;
                        mem_en     = 1'b1;
                        mem_addr   = mem_rdata;
                        state_next = ST_MEM2;
                    end
                    FN_STI:
                    begin
                        wv       = rd_b;
                        mem_en   = 1'b1;
                        mem_we   = 1'b1;
                        mem_addr = mem_rdata;
                    end
                    default:
                    begin
                        wv       = mem_rdata;
                        rf_wr.we = 1'b1;
                        set_cc   = 1'b1;
                    end
                endcase
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MEM2:
            begin
                finish     = 1'b1;
                wv         = mem_rdata;
                rf_wr.we   = 1'b1;
                set_cc     = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        rf_wr.data = wv;
        cc_next    = set_cc ? cc_of(wv) : cc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pc_reg    <= 16'h0000;
            cc_reg    <= CC_Z;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= finish;
            if (finish)
            begin
                pc_reg <= pc_next;
                cc_reg <= cc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= request;
        end
        if (finish)
        begin
            result_reg.pc_value      <= pc_next;
            result_reg.cond_code     <= cc_next;
            result_reg.written_value <= wv;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire
